// File: sv/cpualu_pkg.sv
// cpualu_pkg: operation codes, constants and the control struct shared
// by the ALU stages. No dependencies.
package cpualu_pkg;

	localparam logic [7:0] BYTE_MAX = 8'hFF;
	localparam int unsigned SIGN_BIT = 7;
	localparam logic [7:0] LSB_MASK = 8'b0000_0001;

	typedef enum logic [3:0] {
		FN_ADC  = 4'd0,
		FN_SBB  = 4'd1,
		FN_MUL  = 4'd2,
		FN_DIV  = 4'd3,
		FN_MOD  = 4'd4,
		FN_AND  = 4'd5,
		FN_OR   = 4'd6,
		FN_XOR  = 4'd7,
		FN_SHL  = 4'd8,
		FN_SHR  = 4'd9,
		FN_ROL  = 4'd10,
		FN_ROR  = 4'd11,
		FN_CMP  = 4'd12,
		FN_INC  = 4'd13,
		FN_DEC  = 4'd14,
		FN_LOAD = 4'd15
	} func_t;

	// per-item control carried down the pipe
	typedef struct packed {
		logic [7:0] result;
		logic       carry;
		logic       overflow;
		logic       write_back;
		logic       div_op;
		logic       mod_op;
		logic       dz;
	} ctl_t;

endpackage

// File: sv/cpualu_div_step.sv
// cpualu_div_step: four restoring-division steps on an 8-bit divisor.
// Depends on cpualu_pkg.
module cpualu_div_step
	import cpualu_pkg::*;
(
	input  logic [7:0] rem_in,
	input  logic [3:0] bits,
	input  logic [7:0] divisor,
	output logic [7:0] rem_out,
	output logic [3:0] quo
);

	logic [8:0] r;
	logic [7:0] rr;

	always_comb begin
		rr  = rem_in;
		r   = '0;
		quo = '0;
		for (int i = 3; i >= 0; i--) begin
			r = {rr, bits[i]};
			if (r >= {1'b0, divisor}) begin
				r      = r - {1'b0, divisor};
				quo[i] = 1'b1;
			end
			rr = r[7:0];
		end
		rem_out = rr;
	end

endmodule

// File: sv/cpualu_exec.sv
// cpualu_exec: all operations except the divider datapath; flags that an
// operation leaves alone pass through. Depends on cpualu_pkg.
module cpualu_exec
	import cpualu_pkg::*;
(
	input  logic [3:0] func,
	input  logic [7:0] operand_a,
	input  logic [7:0] operand_b,
	input  logic       carry_in,
	input  logic       overflow_in,
	output ctl_t       ctl
);

	func_t       f;
	logic [8:0]  sum;
	logic [8:0]  diff;
	logic [15:0] prod;

	assign f = func_t'(func);

	always_comb begin
		sum  = {1'b0, operand_a} + {1'b0, operand_b} + {8'd0, carry_in};
		diff = {1'b0, operand_a} - {1'b0, operand_b}
			- {8'd0, (f == FN_SBB) ? carry_in : 1'b0};
		prod = {8'd0, operand_a} * {8'd0, operand_b};

		ctl.result     = operand_b;
		ctl.carry      = carry_in;
		ctl.overflow   = overflow_in;
		ctl.write_back = 1'b1;
		ctl.div_op     = 1'b0;
		ctl.mod_op     = 1'b0;
		ctl.dz         = 1'b0;

		case (f)
			FN_ADC: begin
				ctl.result   = sum[7:0];
				ctl.carry    = sum[8];
				ctl.overflow = (operand_a[SIGN_BIT] == operand_b[SIGN_BIT]) &&
					(sum[SIGN_BIT] != operand_a[SIGN_BIT]);
			end
			FN_SBB, FN_CMP: begin
				ctl.result     = diff[7:0];
				ctl.carry      = diff[8];
				ctl.overflow   = (operand_a[SIGN_BIT] != operand_b[SIGN_BIT]) &&
					(diff[SIGN_BIT] != operand_a[SIGN_BIT]);
				ctl.write_back = (f != FN_CMP);
			end
			FN_MUL: begin
				ctl.result = prod[7:0];
				ctl.carry  = |prod[15:8];
			end
			FN_DIV: begin
				ctl.div_op = 1'b1;
				ctl.dz     = (operand_b == 8'd0);
			end
			FN_MOD: begin
				ctl.div_op = 1'b1;
				ctl.mod_op = 1'b1;
				ctl.dz     = (operand_b == 8'd0);
			end
			FN_AND: ctl.result = operand_a & operand_b;
			FN_OR:  ctl.result = operand_a | operand_b;
			FN_XOR: ctl.result = operand_a ^ operand_b;
			FN_SHL: begin
				ctl.result = {operand_a[6:0], 1'b0};
				ctl.carry  = operand_a[SIGN_BIT];
			end
			FN_SHR: begin
				ctl.result = {1'b0, operand_a[7:1]};
				ctl.carry  = |(operand_a & LSB_MASK);
			end
			FN_ROL: begin
				ctl.result = {operand_a[6:0], carry_in};
				ctl.carry  = operand_a[SIGN_BIT];
			end
			FN_ROR: begin
				ctl.result = {carry_in, operand_a[7:1]};
				ctl.carry  = |(operand_a & LSB_MASK);
			end
			FN_INC: ctl.result = operand_a + 8'd1;
			FN_DEC: ctl.result = operand_a - 8'd1;
			default: ctl.result = operand_b;
		endcase
	end

endmodule

// File: sv/cpu_alu_8bit_with_flags.sv
// cpu_alu_8bit_with_flags: three-stage pipelined 8-bit ALU with flags.
// Depends on cpualu_pkg, cpualu_exec, cpualu_div_step.
//
//  channel | valid     | stall     | payload
//  req     | req_valid | req_stall | func, operand_a, operand_b, carry_in, overflow_in
//  rsp     | rsp_valid | rsp_stall | result, write_back, carry_out, overflow_out,
//          |           |           | zero_out, sign_out, divide_by_zero
//
// One transfer per cycle unless rsp stalls; each req is registered in stages 1, 2, 3.
// Stage 1: operation unit plus divide bits 7..4; stage 2: divide bits 3..0;
// stage 3: result select and zero/sign flags.
// arst_n clears the stage valid bits; the pipe is empty after reset.
// A stall on rsp holds stage 3; earlier stages keep filling until each is full.
module cpu_alu_8bit_with_flags
	import cpualu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [3:0] func,
	input  logic [7:0] operand_a,
	input  logic [7:0] operand_b,
	input  logic       carry_in,
	input  logic       overflow_in,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] result,
	output logic       write_back,
	output logic       carry_out,
	output logic       overflow_out,
	output logic       zero_out,
	output logic       sign_out,
	output logic       divide_by_zero
);

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	ctl_t       ctl_c;
	logic [7:0] rem_hi_c;
	logic [3:0] q_hi_c;

	ctl_t       ctl_s1;
	logic [3:0] a_lo_s1;
	logic [7:0] b_s1;
	logic [7:0] rem_s1;
	logic [3:0] q_hi_s1;

	logic [7:0] rem_lo_c;
	logic [3:0] q_lo_c;

	ctl_t       ctl_s2;
	logic [7:0] rem_s2;
	logic [7:0] q_s2;

	logic [7:0] res_c;

	logic [7:0] res_s3;
	logic       wb_s3, c_s3, v_out_s3, dz_s3;

	assign en3 = !v_s3 || !rsp_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req_stall = !en1;

	cpualu_exec u_exec (
		.func        (func),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.carry_in    (carry_in),
		.overflow_in (overflow_in),
		.ctl         (ctl_c)
	);

	cpualu_div_step u_div_hi (
		.rem_in  (8'd0),
		.bits    (operand_a[7:4]),
		.divisor (operand_b),
		.rem_out (rem_hi_c),
		.quo     (q_hi_c)
	);

	cpualu_div_step u_div_lo (
		.rem_in  (rem_s1),
		.bits    (a_lo_s1),
		.divisor (b_s1),
		.rem_out (rem_lo_c),
		.quo     (q_lo_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			ctl_s1  <= ctl_c;
			a_lo_s1 <= operand_a[3:0];
			b_s1    <= operand_b;
			rem_s1  <= rem_hi_c;
			q_hi_s1 <= q_hi_c;
		end
		if (en2 && v_s1) begin
			ctl_s2 <= ctl_s1;
			rem_s2 <= rem_lo_c;
			q_s2   <= {q_hi_s1, q_lo_c};
		end
		if (en3 && v_s2) begin
			res_s3   <= res_c;
			wb_s3    <= ctl_s2.write_back;
			c_s3     <= ctl_s2.carry;
			v_out_s3 <= ctl_s2.overflow;
			dz_s3    <= ctl_s2.dz;
		end
	end

	always_comb begin
		if (ctl_s2.dz) begin
			res_c = BYTE_MAX;
		end else if (ctl_s2.mod_op) begin
			res_c = rem_s2;
		end else if (ctl_s2.div_op) begin
			res_c = q_s2;
		end else begin
			res_c = ctl_s2.result;
		end
	end

	assign rsp_valid      = v_s3;
	assign result         = res_s3;
	assign write_back     = wb_s3;
	assign carry_out      = c_s3;
	assign overflow_out   = v_out_s3;
	assign zero_out       = (res_s3 == 8'd0);
	assign sign_out       = res_s3[SIGN_BIT];
	assign divide_by_zero = dz_s3;

	a_dz_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && divide_by_zero |-> result == BYTE_MAX)
		else $error("zero divisor without saturated result");

	a_s1_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && en2 |=> v_s2)
		else $error("stage 1 item lost on advance");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en3 |=> v_s2 && $stable(res_c))
		else $error("stalled stage 2 item changed");

	a_cmp_wb: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ctl_s2.write_back |-> !ctl_s2.div_op)
		else $error("compare flagged as divide");

endmodule
